/* hdl/kmpt_pkg.sv */
`timescale 1ns / 1ps

package kmpt_pkg;

    localparam int KIND_W   = 2;
    localparam int TASK_W   = 16;
    localparam int USER_W   = 16;
    localparam int PRIO_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDIT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EXEC   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TASK_W-1:0] task_id;
        logic [USER_W-1:0] user_id;
        logic [PRIO_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [USER_W-1:0]   owner_user;
        logic [STATUS_W-1:0] status;
    } rsp_t;

endpackage

/* hdl/kmpt_ram.sv */
`timescale 1ns / 1ps

module kmpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/keyed_max_priority_task_table_top.sv */
`timescale 1ns / 1ps

// Task table keyed by task id, holding up to CAPACITY tasks in one RAM whose
// words carry a valid flag, the task id, the owning user and the priority.
// Every request (add, change priority, remove, execute top) scans all slots
// through the single read port, one slot per cycle, then writes back at most
// one slot. The result sits in an output register, so the next request may be
// accepted while it waits. After reset the block clears every RAM slot and
// holds s_ready low meanwhile. Execute removes the valid task of highest
// priority, ties to the larger task id, and returns its owning user.

module keyed_max_priority_task_table_top
    import kmpt_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int TASK_ID_BITS  = 16,
    parameter int USER_ID_BITS  = 16,
    parameter int PRIORITY_BITS = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_payload,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_payload
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int KEY_W  = (TASK_ID_BITS < TASK_W) ? TASK_ID_BITS : TASK_W;
    localparam int USR_W  = (USER_ID_BITS < USER_W) ? USER_ID_BITS : USER_W;
    localparam int PRI_W  = (PRIORITY_BITS < PRIO_W) ? PRIORITY_BITS : PRIO_W;
    localparam int WORD_W = 1 + KEY_W + USR_W + PRI_W;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(CAPACITY);

    typedef enum logic [3:0] {
        STATE_CLEAR  = 4'b0001,
        STATE_IDLE   = 4'b0010,
        STATE_SCAN   = 4'b0100,
        STATE_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rvalid_reg, rvalid_next;
    logic [ADDR_W-1:0] ridx_reg, ridx_next;
    logic              m_valid_reg, m_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [USR_W-1:0]  user_reg, user_next;
    logic [PRI_W-1:0]  prio_reg, prio_next;

    logic              found_reg, found_next;
    logic [ADDR_W-1:0] found_idx_reg, found_idx_next;
    logic [USR_W-1:0]  found_user_reg, found_user_next;
    logic              free_reg, free_next;
    logic [ADDR_W-1:0] free_idx_reg, free_idx_next;
    logic              best_reg, best_next;
    logic [ADDR_W-1:0] best_idx_reg, best_idx_next;
    logic [PRI_W-1:0]  best_prio_reg, best_prio_next;
    logic [KEY_W-1:0]  best_task_reg, best_task_next;
    logic [USR_W-1:0]  best_user_reg, best_user_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic              e_valid;
    logic [KEY_W-1:0]  e_task;
    logic [USR_W-1:0]  e_user;
    logic [PRI_W-1:0]  e_prio;
    logic              out_free;

    kmpt_ram #(
        .WIDTH(WORD_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign e_valid = ram_rdata[WORD_W-1];
    assign e_task  = ram_rdata[USR_W+PRI_W +: KEY_W];
    assign e_user  = ram_rdata[PRI_W +: USR_W];
    assign e_prio  = ram_rdata[PRI_W-1:0];

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == STATE_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = rsp_reg;
    assign ram_raddr = cnt_reg[ADDR_W-1:0];

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rvalid_next     = 1'b0;
        ridx_next       = ridx_reg;
        m_valid_next    = m_valid_reg;
        rsp_next        = rsp_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        user_next       = user_reg;
        prio_next       = prio_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_user_next = found_user_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_task_next  = best_task_reg;
        best_user_next  = best_user_reg;
        ram_we          = 1'b0;
        ram_waddr       = found_idx_reg;
        ram_wdata       = {1'b1, key_reg, user_reg, prio_reg};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            STATE_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[ADDR_W-1:0];
                ram_wdata = '0;
                if (cnt_reg == CNT_END - CNT_W'(1)) begin
                    cnt_next   = '0;
                    state_next = STATE_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            STATE_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_payload.kind;
                    key_next   = s_payload.task_id[KEY_W-1:0];
                    user_next  = s_payload.user_id[USR_W-1:0];
                    prio_next  = s_payload.priority_req[PRI_W-1:0];
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    best_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = STATE_SCAN;
                end
            end
            STATE_SCAN: begin
                // issue one read per cycle, compare the slot read last cycle
                if (cnt_reg != CNT_END) begin
                    rvalid_next = 1'b1;
                    ridx_next   = cnt_reg[ADDR_W-1:0];
                    cnt_next    = cnt_reg + CNT_W'(1);
                end else begin
                    state_next = STATE_FINISH;
                end
                if (rvalid_reg) begin
                    if (e_valid && e_task == key_reg && !found_reg) begin
                        found_next      = 1'b1;
                        found_idx_next  = ridx_reg;
                        found_user_next = e_user;
                    end
                    if (!e_valid && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = ridx_reg;
                    end
                    if (e_valid && (!best_reg || e_prio > best_prio_reg ||
                        (e_prio == best_prio_reg && e_task > best_task_reg))) begin
                        best_next      = 1'b1;
                        best_idx_next  = ridx_reg;
                        best_prio_next = e_prio;
                        best_task_next = e_task;
                        best_user_next = e_user;
                    end
                end
            end
            STATE_FINISH: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    rsp_next.owner_user = '0;
                    rsp_next.status     = STATUS_DONE;
                    state_next          = STATE_IDLE;
                    case (kind_reg)
                        KIND_ADD: begin
                            if (found_reg) begin
                                ram_we = 1'b1;
                            end else if (free_reg) begin
                                ram_we    = 1'b1;
                                ram_waddr = free_idx_reg;
                            end else begin
                                rsp_next.status = STATUS_FULL;
                            end
                        end
                        KIND_EDIT: begin
                            if (found_reg) begin
                                ram_we    = 1'b1;
                                ram_wdata = {1'b1, key_reg, found_user_reg, prio_reg};
                            end else begin
                                rsp_next.status = STATUS_UNKNOWN;
                            end
                        end
                        KIND_REMOVE: begin
                            if (found_reg) begin
                                ram_we    = 1'b1;
                                ram_wdata = '0;
                            end else begin
                                rsp_next.status = STATUS_UNKNOWN;
                            end
                        end
                        default: begin
                            if (best_reg) begin
                                ram_we              = 1'b1;
                                ram_waddr           = best_idx_reg;
                                ram_wdata           = '0;
                                rsp_next.owner_user = USER_W'(best_user_reg);
                            end else begin
                                rsp_next.status = STATUS_EMPTY;
                            end
                        end
                    endcase
                end
            end
            default: begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_CLEAR;
            cnt_reg     <= '0;
            rvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
            best_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rvalid_reg  <= rvalid_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
            free_reg    <= free_next;
            best_reg    <= best_next;
        end
    end

    always_ff @(posedge aclk) begin
        ridx_reg       <= ridx_next;
        rsp_reg        <= rsp_next;
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        user_reg       <= user_next;
        prio_reg       <= prio_next;
        found_idx_reg  <= found_idx_next;
        found_user_reg <= found_user_next;
        free_idx_reg   <= free_idx_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_task_reg  <= best_task_next;
        best_user_reg  <= best_user_next;
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import kmpt_pkg::*;

    localparam int SLOTS = 64;

    class task_table_scoreboard;
        bit               slot_live[SLOTS];
        logic [TASK_W-1:0] slot_key[SLOTS];
        logic [USER_W-1:0] slot_owner[SLOTS];
        logic [PRIO_W-1:0] slot_prio[SLOTS];
        rsp_t             expected_q[$];
        int               errors;

        function new();
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // work out the outcome of one accepted request and update the table
        function void note_request(req_t r);
            rsp_t rsp;
            int   hit;
            int   pick;
            hit = -1;
            pick = -1;
            rsp.owner_user = '0;
            rsp.status = STATUS_DONE;
            for (int i = 0; i < SLOTS; i++) begin
                if (hit < 0 && slot_live[i] && slot_key[i] == r.task_id) hit = i;
            end
            case (r.kind)
                KIND_ADD: begin
                    if (hit < 0) begin
                        for (int i = SLOTS - 1; i >= 0; i--) begin
                            if (!slot_live[i]) hit = i;
                        end
                        if (hit < 0) begin
                            rsp.status = STATUS_FULL;
                        end else begin
                            slot_live[hit] = 1'b1;
                            slot_key[hit] = r.task_id;
                        end
                    end
                    if (hit >= 0) begin
                        slot_owner[hit] = r.user_id;
                        slot_prio[hit] = r.priority_req;
                    end
                end
                KIND_EDIT: begin
                    if (hit < 0) rsp.status = STATUS_UNKNOWN;
                    else slot_prio[hit] = r.priority_req;
                end
                KIND_REMOVE: begin
                    if (hit < 0) rsp.status = STATUS_UNKNOWN;
                    else slot_live[hit] = 1'b0;
                end
                default: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_live[i]) begin
                            if (pick < 0 || slot_prio[i] > slot_prio[pick] ||
                                (slot_prio[i] == slot_prio[pick] &&
                                 slot_key[i] > slot_key[pick])) pick = i;
                        end
                    end
                    if (pick < 0) begin
                        rsp.status = STATUS_EMPTY;
                    end else begin
                        rsp.owner_user = slot_owner[pick];
                        slot_live[pick] = 1'b0;
                    end
                end
            endcase
            expected_q.push_back(rsp);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: owner_user %0h status %0d",
                       got.owner_user, got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.owner_user !== want.owner_user) begin
                $error("owner_user: expected %0h, actual %0h", want.owner_user, got.owner_user);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_payload;

    task_table_scoreboard sb = new();
    logic [TASK_W-1:0] id_pool[96];
    bit no_gaps = 1'b0;

    keyed_max_priority_task_table_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_payload);
        m_ready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 22);
    end

    task automatic send_request(req_t r);
        s_valid <= 1'b1;
        s_payload <= r;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
        if (!no_gaps && $urandom_range(0, 99) < 22) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    endtask

    task automatic send_fields(logic [KIND_W-1:0] k, logic [TASK_W-1:0] t,
                               logic [USER_W-1:0] u, logic [PRIO_W-1:0] p);
        req_t r;
        r.kind = k;
        r.task_id = t;
        r.user_id = u;
        r.priority_req = p;
        send_request(r);
    endtask

    // hold off new requests until the table has answered everything
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    function automatic req_t random_request(int add_pct);
        req_t r;
        r.kind = KIND_EXEC;
        if ($urandom_range(0, 99) < add_pct) begin
            r.kind = KIND_ADD;
        end else begin
            case ($urandom_range(0, 2))
                0: r.kind = KIND_EDIT;
                1: r.kind = KIND_REMOVE;
                default: r.kind = KIND_EXEC;
            endcase
        end
        r.task_id = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, 95)]
                                                : TASK_W'($urandom);
        r.user_id = USER_W'($urandom);
        r.priority_req = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom_range(0, 3))
                                                      : PRIO_W'($urandom);
        return r;
    endfunction

    initial begin
        int add_mix[5];
        add_mix = '{85, 35, 90, 20, 60};
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < 96; i++) id_pool[i] = TASK_W'($urandom);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table and unknown keys
        send_fields(KIND_EXEC,   16'h0000, 16'h0000, 32'h0000_0000);
        send_fields(KIND_EDIT,   16'h0005, 16'h0000, 32'h0000_0001);
        send_fields(KIND_REMOVE, 16'h0005, 16'h0000, 32'h0000_0000);
        // field extremes, overwrite and ties
        send_fields(KIND_ADD,    16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_fields(KIND_ADD,    16'h0000, 16'h0000, 32'h0000_0000);
        send_fields(KIND_ADD,    16'h1234, 16'hABCD, 32'h0000_0007);
        send_fields(KIND_ADD,    16'h1234, 16'h5555, 32'h0000_0007);
        send_fields(KIND_ADD,    16'h0100, 16'h1111, 32'h0000_0007);
        send_fields(KIND_EDIT,   16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_fields(KIND_EXEC,   16'h0000, 16'h0000, 32'h0000_0000);
        send_fields(KIND_EXEC,   16'h0000, 16'h0000, 32'h0000_0000);
        send_fields(KIND_EXEC,   16'h0000, 16'h0000, 32'h0000_0000);
        send_fields(KIND_EDIT,   16'h0100, 16'hFFFF, 32'h0000_0000);
        send_fields(KIND_REMOVE, 16'h0100, 16'h0000, 32'h0000_0000);
        send_fields(KIND_REMOVE, 16'h0100, 16'h0000, 32'h0000_0000);
        send_fields(KIND_EXEC,   16'h0000, 16'h0000, 32'h0000_0000);
        send_fields(KIND_ADD,    16'hA5A5, 16'h5A5A, 32'h5A5A_A5A5);
        send_fields(KIND_EXEC,   16'h0000, 16'h0000, 32'h0000_0000);
        drain_results();

        for (int phase = 0; phase < 5; phase++) begin
            no_gaps = (phase == 2);
            for (int n = 0; n < 150; n++) send_request(random_request(add_mix[phase]));
            if (phase == 1) drain_results();
        end
        no_gaps = 1'b0;

        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
